// ----- rtl/madmse_pkg.sv -----
`default_nettype none

package madmse_pkg;

	localparam int MAX_DIMENSION = 4096;
	localparam int MAX_CHANNELS  = 4;
	localparam int PIXEL_BITS    = 8;

	// register field widths
	localparam int WIDTH_W  = 13;
	localparam int HEIGHT_W = 13;
	localparam int CHAN_W   = 3;
	localparam int MARGIN_W = 11;

	// result field widths
	localparam int SUM_W     = 42;
	localparam int CNT_W     = 27;
	localparam int MSE_W     = 24;
	localparam int FRAC_BITS = 8;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = WIDTH_W'(640);
	localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = HEIGHT_W'(480);
	localparam logic [CHAN_W-1:0]   RESET_CHAN   = CHAN_W'(3);
	localparam logic [MARGIN_W-1:0] RESET_MARGIN = '0;

	localparam int DIM_W     = $clog2(MAX_DIMENSION + 1);
	localparam int POS_W     = $clog2(MAX_DIMENSION);
	localparam int CH_EFF_W  = $clog2(MAX_CHANNELS + 1);
	localparam int PLANE_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int PL_CMP_W  = ((PLANE_W > CH_EFF_W) ? PLANE_W : CH_EFF_W) + 1;
	localparam int CMP_W     = ((DIM_W > MARGIN_W) ? DIM_W : MARGIN_W) + 1;
	localparam int SQ_W      = 2 * PIXEL_BITS;
	localparam int NUM_W     = SUM_W + FRAC_BITS + 1;
	localparam int DIV_CNT_W = $clog2(NUM_W);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef logic [PIXEL_BITS-1:0] pixel_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH   = CFG_IDX_W'(0),
		REG_IMAGE_HEIGHT  = CFG_IDX_W'(1),
		REG_CHANNEL_COUNT = CFG_IDX_W'(2),
		REG_BORDER_MARGIN = CFG_IDX_W'(3)
	} cfg_reg_t;

	typedef struct packed {
		pixel_t diff;
		logic   in_window;
		logic   frame_end;
	} qentry_t;

	typedef enum logic [1:0] {
		BK_ACC,
		BK_PREP,
		BK_DIV,
		BK_HOLD
	} back_state_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [WIDTH_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = DIM_W'(1);
		else if (int'(v) > MAX_DIMENSION)
			r = DIM_W'(MAX_DIMENSION);
		else
			r = DIM_W'(v);
		return r;
	endfunction

	function automatic logic [CH_EFF_W-1:0] clamp_chan(input logic [CHAN_W-1:0] v);
		logic [CH_EFF_W-1:0] r;
		if (v == '0)
			r = CH_EFF_W'(1);
		else if (int'(v) > MAX_CHANNELS)
			r = CH_EFF_W'(MAX_CHANNELS);
		else
			r = CH_EFF_W'(v);
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/madmse_pix_if.sv -----
`default_nettype none

interface madmse_pix_if;
	import madmse_pkg::*;

	logic   valid;
	logic   ready;
	pixel_t pixel_ref;
	pixel_t pixel_test;

	modport source(output valid, pixel_ref, pixel_test, input ready);
	modport sink(input valid, pixel_ref, pixel_test, output ready);
endinterface

`default_nettype wire

// ----- rtl/madmse_res_if.sv -----
`default_nettype none

interface madmse_res_if;
	import madmse_pkg::*;

	logic             valid;
	logic             ready;
	pixel_t           max_abs_diff;
	logic [SUM_W-1:0] sum_sq_diff;
	logic [CNT_W-1:0] pixel_total;
	logic [MSE_W-1:0] mse_fixed;
	logic             window_empty;

	modport source(output valid, max_abs_diff, sum_sq_diff, pixel_total, mse_fixed,
		window_empty, input ready);
	modport sink(input valid, max_abs_diff, sum_sq_diff, pixel_total, mse_fixed,
		window_empty, output ready);
endinterface

`default_nettype wire

// ----- rtl/madmse_cfg_if.sv -----
`default_nettype none

interface madmse_cfg_if;
	import madmse_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/image_max_abs_diff_and_mse_core.sv -----
`default_nettype none

// Channel   Dir  Payload
// pix_in    in   pixel_ref, pixel_test (one per pixel, planar raster order)
// res_out   out  max_abs_diff, sum_sq_diff, pixel_total, mse_fixed, window_empty
// cfg       in   index, data (0 width, 1 height, 2 channel count, 3 margin)
//
// One pixel per cycle enters the front and a 4-entry queue while it has room; the back drains
// it at one per cycle while accumulating. On the last pixel of a frame the back runs a restoring
// divider, one quotient bit per cycle (setup, 51 steps, output load), while the queue fills
// and pix_in stalls. An empty window skips the divider. res_out is a register: the back keeps
// accumulating while a result waits, and stalls only when a second result is ready first.
// Reset restores register defaults and clears state; a known register write restarts the frame.
module image_max_abs_diff_and_mse_core (
	input  wire logic    clk,
	input  wire logic    arst_n,
	madmse_cfg_if.sink   cfg,
	madmse_pix_if.sink   pix_in,
	madmse_res_if.source res_out
);
	import madmse_pkg::*;

	logic    q_push, q_full, q_pop, q_nonempty, frame_clear;
	qentry_t push_entry, pop_entry;

	madmse_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.pix_in      (pix_in),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_entry     (push_entry),
		.frame_clear (frame_clear)
	);

	madmse_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.nonempty   (q_nonempty),
		.pop_entry  (pop_entry)
	);

	madmse_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_clear (frame_clear),
		.q_nonempty  (q_nonempty),
		.q_entry     (pop_entry),
		.q_pop       (q_pop),
		.res_out     (res_out)
	);

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && res_out.window_empty |->
			res_out.max_abs_diff == '0 && res_out.sum_sq_diff == '0 &&
			res_out.pixel_total == '0 && res_out.mse_fixed == '0)
		else $error("empty window result carries nonzero fields");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && !res_out.window_empty |-> res_out.pixel_total != '0)
		else $error("non-empty result with zero pixel count");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("push into full queue");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_nonempty)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- rtl/madmse_front.sv -----
`default_nettype none

module madmse_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	madmse_cfg_if.sink             cfg,
	madmse_pix_if.sink             pix_in,
	input  wire logic              q_full,
	output logic                   q_push,
	output madmse_pkg::qentry_t    q_entry,
	output logic                   frame_clear
);
	import madmse_pkg::*;

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [CHAN_W-1:0]   chan_q;
	logic [MARGIN_W-1:0] margin_q;

	logic [POS_W-1:0]   col_q;
	logic [POS_W-1:0]   row_q;
	logic [PLANE_W-1:0] plane_q;

	logic [CMP_W-1:0]    col_ext, row_ext, m_ext, w_ext, h_ext;
	logic [PL_CMP_W-1:0] plane_ext, c_ext;
	logic                last_col, last_row, last_plane;
	logic                in_window;
	logic                cfg_write;
	pixel_t              diff;

	assign cfg.ready    = 1'b1;
	assign cfg_write    = cfg.valid && cfg.ready;
	assign pix_in.ready = !q_full;
	assign q_push       = pix_in.valid && !q_full;

	always_comb begin
		w_ext     = CMP_W'(clamp_dim(width_q));
		h_ext     = CMP_W'(clamp_dim(height_q));
		c_ext     = PL_CMP_W'(clamp_chan(chan_q));
		m_ext     = CMP_W'(margin_q);
		col_ext   = CMP_W'(col_q);
		row_ext   = CMP_W'(row_q);
		plane_ext = PL_CMP_W'(plane_q);

		last_col   = (col_ext + CMP_W'(1)) >= w_ext;
		last_row   = (row_ext + CMP_W'(1)) >= h_ext;
		last_plane = (plane_ext + PL_CMP_W'(1)) >= c_ext;

		in_window = (col_ext >= m_ext) && ((col_ext + m_ext) < w_ext) &&
			(row_ext >= m_ext) && ((row_ext + m_ext) < h_ext);

		diff = (pix_in.pixel_ref > pix_in.pixel_test) ?
			pix_in.pixel_ref - pix_in.pixel_test :
			pix_in.pixel_test - pix_in.pixel_ref;

		q_entry.diff      = diff;
		q_entry.in_window = in_window;
		q_entry.frame_end = last_col && last_row && last_plane;
	end

	// any known register write restarts the frame
	always_comb begin
		unique case (cfg_reg_t'(cfg.index))
			REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_CHANNEL_COUNT, REG_BORDER_MARGIN:
				frame_clear = cfg_write;
			default: frame_clear = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
			chan_q   <= RESET_CHAN;
			margin_q <= RESET_MARGIN;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_IMAGE_WIDTH:   width_q  <= cfg.data[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT:  height_q <= cfg.data[HEIGHT_W-1:0];
				REG_CHANNEL_COUNT: chan_q   <= cfg.data[CHAN_W-1:0];
				REG_BORDER_MARGIN: margin_q <= cfg.data[MARGIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			plane_q <= '0;
		end else if (frame_clear) begin
			col_q   <= '0;
			row_q   <= '0;
			plane_q <= '0;
		end else if (q_push) begin
			if (!last_col) begin
				col_q <= col_q + POS_W'(1);
			end else begin
				col_q <= '0;
				if (!last_row) begin
					row_q <= row_q + POS_W'(1);
				end else begin
					row_q <= '0;
					if (!last_plane)
						plane_q <= plane_q + PLANE_W'(1);
					else
						plane_q <= '0;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/madmse_fifo.sv -----
`default_nettype none

module madmse_fifo (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire madmse_pkg::qentry_t  push_entry,
	output logic                      full,
	input  wire logic                 pop,
	output logic                      nonempty,
	output madmse_pkg::qentry_t       pop_entry
);
	import madmse_pkg::*;

	qentry_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push, do_pop;

	assign full      = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign nonempty  = (count_q != '0);
	assign pop_entry = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && nonempty;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + (QPTR_W+1)'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - (QPTR_W+1)'(1);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/madmse_back.sv -----
`default_nettype none

module madmse_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 frame_clear,
	input  wire logic                 q_nonempty,
	input  wire madmse_pkg::qentry_t  q_entry,
	output logic                      q_pop,
	madmse_res_if.source              res_out
);
	import madmse_pkg::*;

	back_state_t state_q, state_d;

	pixel_t               acc_max_q;
	logic [SUM_W-1:0]     acc_sum_q;
	logic [CNT_W-1:0]     acc_cnt_q;
	pixel_t               snap_max_q;
	logic [SUM_W-1:0]     snap_sum_q;
	logic [CNT_W-1:0]     snap_cnt_q;
	logic [NUM_W-1:0]     num_q;
	logic [CNT_W-1:0]     rem_q;
	logic [MSE_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] step_q;

	logic                 out_valid_q;
	pixel_t               out_max_q;
	logic [SUM_W-1:0]     out_sum_q;
	logic [CNT_W-1:0]     out_cnt_q;
	logic [MSE_W-1:0]     out_mse_q;
	logic                 out_empty_q;

	pixel_t           max_next;
	logic [SQ_W-1:0]  sq;
	logic [SUM_W-1:0] sum_next;
	logic [CNT_W-1:0] cnt_next;
	logic [CNT_W:0]   trial;
	logic             trial_ge;
	logic             load_out;

	always_comb begin
		sq       = SQ_W'(q_entry.diff) * SQ_W'(q_entry.diff);
		max_next = acc_max_q;
		sum_next = acc_sum_q;
		cnt_next = acc_cnt_q;
		if (q_entry.in_window) begin
			if (q_entry.diff > acc_max_q)
				max_next = q_entry.diff;
			sum_next = acc_sum_q + SUM_W'(sq);
			cnt_next = acc_cnt_q + CNT_W'(1);
		end
		trial    = {rem_q, num_q[NUM_W-1]};
		trial_ge = trial >= {1'b0, snap_cnt_q};
	end

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			BK_ACC: begin
				q_pop = q_nonempty;
				if (q_nonempty && q_entry.frame_end)
					state_d = (cnt_next == '0) ? BK_HOLD : BK_PREP;
			end
			BK_PREP: state_d = BK_DIV;
			BK_DIV: begin
				if (step_q == '0)
					state_d = BK_HOLD;
			end
			BK_HOLD: begin
				load_out = !out_valid_q || res_out.ready;
				if (load_out)
					state_d = BK_ACC;
			end
			default: state_d = BK_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_ACC;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_max_q <= '0;
			acc_sum_q <= '0;
			acc_cnt_q <= '0;
		end else if (frame_clear || (q_pop && q_entry.frame_end)) begin
			acc_max_q <= '0;
			acc_sum_q <= '0;
			acc_cnt_q <= '0;
		end else if (q_pop) begin
			acc_max_q <= max_next;
			acc_sum_q <= sum_next;
			acc_cnt_q <= cnt_next;
		end
	end

	// snapshot and restoring divider: one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (q_pop && q_entry.frame_end) begin
			snap_max_q <= max_next;
			snap_sum_q <= sum_next;
			snap_cnt_q <= cnt_next;
			quo_q      <= '0;
		end else if (state_q == BK_PREP) begin
			num_q  <= (NUM_W'(snap_sum_q) << FRAC_BITS) + NUM_W'(snap_cnt_q >> 1);
			rem_q  <= '0;
			quo_q  <= '0;
			step_q <= DIV_CNT_W'(NUM_W - 1);
		end else if (state_q == BK_DIV) begin
			rem_q  <= trial_ge ? CNT_W'(trial - {1'b0, snap_cnt_q}) : CNT_W'(trial);
			quo_q  <= {quo_q[MSE_W-2:0], trial_ge};
			num_q  <= num_q << 1;
			step_q <= step_q - DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (res_out.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_max_q   <= snap_max_q;
			out_sum_q   <= snap_sum_q;
			out_cnt_q   <= snap_cnt_q;
			out_mse_q   <= quo_q;
			out_empty_q <= (snap_cnt_q == '0);
		end
	end

	assign res_out.valid        = out_valid_q;
	assign res_out.max_abs_diff = out_max_q;
	assign res_out.sum_sq_diff  = out_sum_q;
	assign res_out.pixel_total  = out_cnt_q;
	assign res_out.mse_fixed    = out_mse_q;
	assign res_out.window_empty = out_empty_q;

endmodule

`default_nettype wire
